// ===== sv/hcbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder: decoder state,
// result record and the hex digit decode.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // size register and running length register widths
  localparam int SIZE_BITS   = 32;
  localparam int LENGTH_BITS = 32;
  localparam int BYTE_W      = 8;
  localparam int OUT_LEN_W   = 32;
  localparam int TRAIL_W     = 2;

  localparam logic [BYTE_W-1:0]  CHAR_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0]  CHAR_LF     = 8'h0a;
  localparam logic [TRAIL_W-1:0] TRAIL_BYTES = 2'd2;

  typedef enum logic [3:0] {
    PH_LINE  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_TRAIL = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   hex_ended;
    logic                   cr_seen;
    logic [SIZE_BITS-1:0]   chunk_remaining;
    logic [TRAIL_W-1:0]     trailer_left;
    logic [LENGTH_BITS-1:0] total_length;
  } dec_state_t;

  typedef struct packed {
    logic                 valid;
    logic [BYTE_W-1:0]    payload;
    logic                 is_payload;
    logic                 body_done;
    logic [OUT_LEN_W-1:0] body_length;
  } dec_result_t;

  localparam dec_state_t STATE_RESET = '{
    phase:           PH_LINE,
    hex_ended:       1'b0,
    cr_seen:         1'b0,
    chunk_remaining: '0,
    trailer_left:    '0,
    total_length:    '0
  };

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  // ascii hex digit, either case
  function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_digit_t r;
    r.is_hex = 1'b1;
    r.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else begin
      r.is_hex = 1'b0;
    end
    return r;
  endfunction

  // low bits of the running length, zero extended when it is narrower
  function automatic logic [OUT_LEN_W-1:0] to_out_len(input logic [LENGTH_BITS-1:0] v);
    logic [LENGTH_BITS+OUT_LEN_W-1:0] ext;
    ext = {{OUT_LEN_W{1'b0}}, v};
    return ext[OUT_LEN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/hcbd_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_step
// Next state and result of the decoder for one body byte.
// ----------------------------------------------------------------------------
module hcbd_step (
  input  wire hcbd_pkg::dec_state_t          cur,
  input  wire logic [hcbd_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                          start_of_body,
  output hcbd_pkg::dec_state_t               nxt,
  output hcbd_pkg::dec_result_t              res
);

  hcbd_pkg::dec_state_t s;
  hcbd_pkg::hex_digit_t hd;
  logic [hcbd_pkg::SIZE_BITS-1:0] rem_dec;
  logic [hcbd_pkg::TRAIL_W-1:0]   trail_dec;

  always_comb begin
    s         = start_of_body ? hcbd_pkg::STATE_RESET : cur;
    hd        = hcbd_pkg::hex_decode(data_byte);
    rem_dec   = s.chunk_remaining - 1'b1;
    trail_dec = s.trailer_left - 1'b1;
    nxt       = s;
    res       = '0;

    unique case (s.phase)
      hcbd_pkg::PH_LINE: begin
        if (s.cr_seen && data_byte == hcbd_pkg::CHAR_LF) begin
          nxt.cr_seen   = 1'b0;
          nxt.hex_ended = 1'b0;
          if (s.chunk_remaining == '0) begin
            nxt.phase       = hcbd_pkg::PH_DONE;
            res.valid       = 1'b1;
            res.body_done   = 1'b1;
            res.body_length = hcbd_pkg::to_out_len(s.total_length);
          end else begin
            nxt.phase = hcbd_pkg::PH_DATA;
          end
        end else begin
          nxt.cr_seen = (data_byte == hcbd_pkg::CHAR_CR);
          if (!s.hex_ended) begin
            if (hd.is_hex) begin
              nxt.chunk_remaining = {s.chunk_remaining[hcbd_pkg::SIZE_BITS-5:0], hd.value};
            end else begin
              nxt.hex_ended = 1'b1;
            end
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        nxt.chunk_remaining = rem_dec;
        nxt.total_length    = s.total_length + 1'b1;
        if (rem_dec == '0) begin
          nxt.phase        = hcbd_pkg::PH_TRAIL;
          nxt.trailer_left = hcbd_pkg::TRAIL_BYTES;
        end
        res.valid      = 1'b1;
        res.payload    = data_byte;
        res.is_payload = 1'b1;
      end
      hcbd_pkg::PH_TRAIL: begin
        nxt.trailer_left = trail_dec;
        if (trail_dec == '0) begin
          nxt.phase           = hcbd_pkg::PH_LINE;
          nxt.hex_ended       = 1'b0;
          nxt.cr_seen         = 1'b0;
          nxt.chunk_remaining = '0;
        end
      end
      default: begin
        // body complete: bytes are swallowed until the next start of body
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/http_chunked_body_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Chunked transfer body decoder: strips size lines and chunk trailers from a
// byte stream, passes payload bytes out and reports the body length at the
// zero size chunk.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | fields
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | data_byte, start_of_body
//   out     | out_valid / out_ready| payload, is_payload, body_done, body_length
//
// one byte a cycle while in_ready is high: the decoder state register is
// updated in the cycle a request is accepted, and its result (if any) lands
// in the output register at the same edge, so the next cycle already shows it
// in_ready stays high while the output register is empty or being drained,
// so a full stream runs at one byte per clock with out_ready held high
// a stall on the output side holds in_ready low only while a result waits
// rst (synchronous) returns the decoder to the start of a size line and
// empties the output register
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  input  wire  logic                                in_valid,
  output logic                                      in_ready,
  input  wire  logic [hcbd_pkg::BYTE_W-1:0]         data_byte,
  input  wire  logic                                start_of_body,
  output logic                                      out_valid,
  input  wire  logic                                out_ready,
  output logic [hcbd_pkg::BYTE_W-1:0]               payload,
  output logic                                      is_payload,
  output logic                                      body_done,
  output logic [hcbd_pkg::OUT_LEN_W-1:0]            body_length
);

  // decoder state, one record of flops
  hcbd_pkg::dec_state_t  dec_state;
  hcbd_pkg::dec_state_t  dec_state_next;
  hcbd_pkg::dec_result_t step_res;

  // output register
  logic                               res_valid;
  logic [hcbd_pkg::BYTE_W-1:0]        res_payload;
  logic                               res_is_payload;
  logic                               res_body_done;
  logic [hcbd_pkg::OUT_LEN_W-1:0]     res_body_length;

  logic in_fire;
  logic out_fire;

  // room for a new result when empty or draining this cycle
  assign in_ready = !res_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = res_valid && out_ready;

  hcbd_step u_step (
    .cur           (dec_state),
    .data_byte     (data_byte),
    .start_of_body (start_of_body),
    .nxt           (dec_state_next),
    .res           (step_res)
  );

  // state advances only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state <= hcbd_pkg::STATE_RESET;
    end else if (in_fire) begin
      dec_state <= dec_state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire) begin
      res_valid <= step_res.valid;
    end else if (out_fire) begin
      res_valid <= 1'b0;
    end
  end

  // result payload, loaded only when a new result appears
  always_ff @(posedge clk) begin
    if (in_fire && step_res.valid) begin
      res_payload     <= step_res.payload;
      res_is_payload  <= step_res.is_payload;
      res_body_done   <= step_res.body_done;
      res_body_length <= step_res.body_length;
    end
  end

  assign out_valid   = res_valid;
  assign payload     = res_payload;
  assign is_payload  = res_is_payload;
  assign body_done   = res_body_done;
  assign body_length = res_body_length;

endmodule
`default_nettype wire

// ===== sv/hcbd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_checker
// Port level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [hcbd_pkg::BYTE_W-1:0]        payload,
  input wire logic                               is_payload,
  input wire logic                               body_done,
  input wire logic [hcbd_pkg::OUT_LEN_W-1:0]     body_length
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload) &&
      $stable(is_payload) && $stable(body_done) && $stable(body_length))
    else $error("result changed while stalled");

  // every result is exactly one of payload byte or end of body
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_payload != body_done))
    else $error("result is neither or both kinds");

  // length field is only used by the end of body result
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !body_done |-> body_length == '0)
    else $error("body_length set on a payload result");

  // input side is never blocked while the output register is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // a request accepted while the output stalls is impossible
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("request accepted over a pending result");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .payload     (payload),
  .is_payload  (is_payload),
  .body_done   (body_done),
  .body_length (body_length)
);
`default_nettype wire

// ===== test/http_chunked_body_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core_tb
// Self-checking bench for the chunked body decoder. Chunked bodies are built
// byte by byte: size lines in both cases, with leading zeros, extensions, lone
// CR and LF, oversized digit strings, random trailers, junk after the end,
// cut-off bodies and noise. A byte-level decoder in the bench predicts every
// payload and end-of-body result, and the monitor checks them in order while
// both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core_tb;

  // one request on the input channel
  typedef struct packed {
    logic [hcbd_pkg::BYTE_W-1:0] data;
    logic                        sob;
  } body_req_t;

  // one decoded result as the output channel carries it
  typedef struct packed {
    logic [hcbd_pkg::BYTE_W-1:0]    payload;
    logic                           is_payload;
    logic                           body_done;
    logic [hcbd_pkg::OUT_LEN_W-1:0] body_length;
  } body_out_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [hcbd_pkg::BYTE_W-1:0]    data_byte = '0;
  logic                           start_of_body = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [hcbd_pkg::BYTE_W-1:0]    payload;
  logic                           is_payload;
  logic                           body_done;
  logic [hcbd_pkg::OUT_LEN_W-1:0] body_length;

  body_req_t   pending_bytes[$];
  body_out_t   decoded_q[$];
  logic [7:0]  body_bytes[$];
  int          total_pushed   = 0;
  int          accepted_count = 0;
  int          mismatch_count = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;

  // bench copy of the decoder state
  hcbd_pkg::phase_t                 dp_phase;
  logic                             dp_hex_ended;
  logic                             dp_cr_seen;
  logic [hcbd_pkg::SIZE_BITS-1:0]   dp_remaining;
  logic [hcbd_pkg::TRAIL_W-1:0]     dp_trailer_left;
  logic [hcbd_pkg::LENGTH_BITS-1:0] dp_total;

  http_chunked_body_decoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_body (start_of_body),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload       (payload),
    .is_payload    (is_payload),
    .body_done     (body_done),
    .body_length   (body_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_decoder();
    dp_phase        = hcbd_pkg::PH_LINE;
    dp_hex_ended    = 1'b0;
    dp_cr_seen      = 1'b0;
    dp_remaining    = '0;
    dp_trailer_left = '0;
    dp_total        = '0;
  endfunction

  // value of an ascii hex digit, -1 for anything else
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // advance the bench decoder by one byte; returns 1 when a result is due
  function automatic bit decode_byte(input logic [7:0] b, input logic sob,
                                     output body_out_t r);
    int nib;
    r   = '0;
    nib = hex_nibble(b);
    if (sob) clear_decoder();
    case (dp_phase)
      hcbd_pkg::PH_LINE: begin
        // only CR directly followed by LF closes the size line
        if (dp_cr_seen && b == hcbd_pkg::CHAR_LF) begin
          dp_cr_seen   = 1'b0;
          dp_hex_ended = 1'b0;
          if (dp_remaining == '0) begin
            dp_phase      = hcbd_pkg::PH_DONE;
            r.body_done   = 1'b1;
            r.body_length = hcbd_pkg::to_out_len(dp_total);
            return 1'b1;
          end
          dp_phase = hcbd_pkg::PH_DATA;
          return 1'b0;
        end
        dp_cr_seen = (b == hcbd_pkg::CHAR_CR);
        if (!dp_hex_ended) begin
          // high digits fall off the top of the size register
          if (nib < 0) dp_hex_ended = 1'b1;
          else dp_remaining = {dp_remaining[hcbd_pkg::SIZE_BITS-5:0], 4'(nib)};
        end
        return 1'b0;
      end
      hcbd_pkg::PH_DATA: begin
        dp_remaining = dp_remaining - 1'b1;
        dp_total     = dp_total + 1'b1;
        if (dp_remaining == '0) begin
          dp_phase        = hcbd_pkg::PH_TRAIL;
          dp_trailer_left = hcbd_pkg::TRAIL_BYTES;
        end
        r.payload    = b;
        r.is_payload = 1'b1;
        return 1'b1;
      end
      hcbd_pkg::PH_TRAIL: begin
        // trailer content is never looked at
        dp_trailer_left = dp_trailer_left - 1'b1;
        if (dp_trailer_left == '0) begin
          dp_phase     = hcbd_pkg::PH_LINE;
          dp_hex_ended = 1'b0;
          dp_cr_seen   = 1'b0;
          dp_remaining = '0;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_req(input logic [7:0] d, input logic sob);
    body_req_t req;
    req.data      = d;
    req.sob       = sob;
    pending_bytes = {pending_bytes, req};
    total_pushed++;
  endtask

  task automatic put_byte(input logic [7:0] d);
    body_bytes = {body_bytes, d};
  endtask

  // hex digits of v, most significant first, random letter case
  task automatic put_hex(input logic [63:0] v, input int ndig);
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) put_byte(8'h30 + nib);
      else if ($urandom_range(1) != 0) put_byte(8'h61 + nib - 8'd10);
      else put_byte(8'h41 + nib - 8'd10);
    end
  endtask

  // size digits, an optional tail that the decoder must skip, then CR LF
  task automatic put_size_line(input logic [63:0] v, input int ndig);
    int tail;
    put_hex(v, ndig);
    tail = $urandom_range(0, 7);
    case (tail)
      0: begin
        // chunk extension, may hold hex digits that are ignored
        put_byte(";");
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(8'h20, 8'h7e)));
      end
      1: begin
        // lone LF does not end the line
        put_byte(hcbd_pkg::CHAR_LF);
        put_byte(8'($urandom_range(8'h20, 8'h7e)));
      end
      2: begin
        // CR not followed by LF
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(8'($urandom_range(8'h20, 8'h7e)));
      end
      3: begin
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(hcbd_pkg::CHAR_CR);
      end
      default: ;
    endcase
    put_byte(hcbd_pkg::CHAR_CR);
    put_byte(hcbd_pkg::CHAR_LF);
  endtask

  // send the first keep bytes of the built body, the first one opening it
  task automatic flush_body(input int keep);
    for (int i = 0; i < keep; i++) push_req(body_bytes[i], i == 0);
    body_bytes.delete();
  endtask

  task automatic add_body();
    int          sz;
    int          cut;
    logic [63:0] v;
    body_bytes.delete();
    if ($urandom_range(0, 15) == 0) begin
      // plain noise with random body starts
      repeat ($urandom_range(1, 4)) push_req(8'($urandom), 1'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
        // more than eight digits: the size wraps to its low 32 bits
        v = {$urandom, 32'(sz)};
        put_size_line(v, $urandom_range(9, 12));
      end else begin
        put_size_line(64'(sz), ((sz < 16) ? 1 : 2) + $urandom_range(0, 2));
      end
      repeat (sz) put_byte(8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        put_byte(8'($urandom));
        put_byte(8'($urandom));
      end else begin
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(hcbd_pkg::CHAR_LF);
      end
    end
    if ($urandom_range(0, 19) == 0) begin
      // huge chunk, abandoned when the next body starts
      put_size_line(64'($urandom), 8);
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
    end else begin
      // last chunk: zeros or no digits at all
      put_size_line(64'h0, $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
    end
    cut = body_bytes.size();
    if ($urandom_range(0, 11) == 0) cut = $urandom_range(1, cut);
    flush_body(cut);
  endtask

  // ---------------------------------------------------------------------------
  // driver: holds each request until it is taken, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    body_req_t nxt;
    body_out_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_count++;
        if (decode_byte(data_byte, start_of_body, res)) decoded_q = {decoded_q, res};
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid      <= 1'b1;
          data_byte     <= nxt.data;
          start_of_body <= nxt.sob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    body_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result", 32'({is_payload, body_done, payload}), 32'd0);
      end else begin
        want = decoded_q.pop_front();
        if (payload !== want.payload)
          report_mismatch("payload", 32'(payload), 32'(want.payload));
        if (is_payload !== want.is_payload)
          report_mismatch("is_payload", 32'(is_payload), 32'(want.is_payload));
        if (body_done !== want.body_done)
          report_mismatch("body_done", 32'(body_done), 32'(want.body_done));
        if (body_length !== want.body_length)
          report_mismatch("body_length", 32'(body_length), 32'(want.body_length));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int target;
    clear_decoder();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_gap_pct = 29; recv_stall_pct = 78; end
        1: begin send_gap_pct = 78; recv_stall_pct = 29; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      if (p == 0) begin
        // empty line right away: no digits, body of length zero
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(hcbd_pkg::CHAR_LF);
        flush_body(body_bytes.size());
        // nine digits wrap to size one, lone LF inside the line, random
        // trailer, then junk after the end
        put_hex(64'hF_0000_0001, 9);
        put_byte(hcbd_pkg::CHAR_LF);
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(hcbd_pkg::CHAR_LF);
        put_byte(8'hFF);
        put_byte(8'($urandom));
        put_byte(8'($urandom));
        put_byte("0");
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(hcbd_pkg::CHAR_LF);
        put_byte("z");
        flush_body(body_bytes.size());
        // new body started in the middle of a chunk's payload
        put_byte("2");
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(hcbd_pkg::CHAR_LF);
        put_byte(8'h00);
        flush_body(body_bytes.size());
        put_byte("0");
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(hcbd_pkg::CHAR_LF);
        flush_body(body_bytes.size());
      end
      target = total_pushed + 170;
      while (total_pushed < target) add_body();
      while (accepted_count != total_pushed) @(posedge clk);
    end

    while (decoded_q.size() != 0) @(posedge clk);
    // catch any result that should not be there
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/hcbd_pkg.sv
sv/hcbd_step.sv
sv/http_chunked_body_decoder_core.sv
sv/hcbd_checker.sv
test/http_chunked_body_decoder_core_tb.sv
